FILE: rtl/assert_macros.svh
// assertion macros used by mwa_dp
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define MWA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define MWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MWA_ASSERT(lbl, clk, rstn, prop)
`define MWA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/mwa_pkg.sv
// shared types and constants of the assignment solver
// no dependencies
package mwa_pkg;

  localparam int ROW_BITS    = 4;
  localparam int COL_BITS    = 4;
  localparam int WIN_BITS    = 16;
  localparam int TOTAL_BITS  = 20;
  localparam int SIZE_BITS   = 5;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 5'd16;
  localparam int APB_AW      = 3;
  localparam logic [APB_AW-1:0] REG_SIZE_ADDR = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ROW_INIT, S_SETUP, S_SCAN_RD, S_SCAN_EV,
    S_UPDATE, S_CHECK, S_AUG, S_SUM_RD, S_SUM_ADD, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_START, CMD_ROW_INIT, CMD_SETUP, CMD_SCAN_RD, CMD_SCAN_EV,
    CMD_UPDATE, CMD_AUG, CMD_SUM_RD, CMD_SUM_ADD, CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic j_last;
    logic owner_zero;
    logic aug_last;
    logic row_last;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: rtl/mwa_if.sv
// valid/ready channel interfaces for matrix entries and results
// depends on mwa_pkg
interface mwa_in_if;
  import mwa_pkg::*;
  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row_index;
  logic [COL_BITS-1:0] col_index;
  logic [WIN_BITS-1:0] weight;
  logic                last_entry;
  modport source(output valid, row_index, col_index, weight, last_entry, input ready);
  modport sink(input valid, row_index, col_index, weight, last_entry, output ready);
endinterface

interface mwa_out_if;
  import mwa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TOTAL_BITS-1:0] total_weight;
  modport source(output valid, total_weight, input ready);
  modport sink(input valid, total_weight, output ready);
endinterface

FILE: rtl/mwa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/mwa_ctrl.sv
// solver sequencer: accepts entries while idle, steps the datapath through each row, then sums and emits the total
// depends on mwa_pkg
module mwa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  mwa_pkg::dp_status_t status_i,
  output mwa_pkg::dp_cmd_t    cmd_o
);
  import mwa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_last_i) state_d = S_START;
      end
      S_START: begin
        cmd_o.op = CMD_START;
        state_d  = S_ROW_INIT;
      end
      S_ROW_INIT: begin
        cmd_o.op = CMD_ROW_INIT;
        state_d  = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.op = CMD_SETUP;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = CMD_SCAN_RD;
        state_d  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.op = CMD_SCAN_EV;
        state_d  = status_i.j_last ? S_UPDATE : S_SCAN_RD;
      end
      S_UPDATE: begin
        cmd_o.op = CMD_UPDATE;
        if (status_i.j_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = status_i.owner_zero ? S_AUG : S_SETUP;
      end
      S_AUG: begin
        cmd_o.op = CMD_AUG;
        if (status_i.aug_last) begin
          state_d = status_i.row_last ? S_SUM_RD : S_ROW_INIT;
        end
      end
      S_SUM_RD: begin
        cmd_o.op = CMD_SUM_RD;
        state_d  = S_SUM_ADD;
      end
      S_SUM_ADD: begin
        cmd_o.op = CMD_SUM_ADD;
        state_d  = status_i.j_last ? S_DONE : S_SUM_RD;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.op = CMD_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/mwa_dp.sv
// solver datapath: weight ram, potentials, slack, matching, result register
// depends on mwa_pkg, mwa_ram, assert_macros.svh
`include "assert_macros.svh"
module mwa_dp #(
  parameter int MAX_SIZE    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(MAX_SIZE+1)-1:0]    n_i,
  input  logic                             wr_en_i,
  input  logic [mwa_pkg::ROW_BITS-1:0]     wr_row_i,
  input  logic [mwa_pkg::COL_BITS-1:0]     wr_col_i,
  input  logic [mwa_pkg::WIN_BITS-1:0]     wr_weight_i,
  input  mwa_pkg::dp_cmd_t                 cmd_i,
  output mwa_pkg::dp_status_t              status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mwa_pkg::TOTAL_BITS-1:0]   out_total_o
);
  import mwa_pkg::*;

  localparam int SIDE  = MAX_SIZE + 1;
  localparam int CW    = $clog2(MAX_SIZE + 1);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = WEIGHT_BITS + $clog2(MAX_SIZE) + 3;
  localparam int TW    = WEIGHT_BITS + $clog2(MAX_SIZE) + 1;
  localparam logic [TW+TOTAL_BITS-1:0] SAT_LIMIT = (TW+TOTAL_BITS)'({TOTAL_BITS{1'b1}});

  logic signed [DW-1:0] pu_q    [SIDE];
  logic signed [DW-1:0] pv_q    [SIDE];
  logic signed [DW-1:0] slack_q [SIDE];
  logic [CW-1:0]        owner_q [SIDE];
  logic [CW-1:0]        pred_q  [SIDE];
  logic [SIDE-1:0]      used_q;
  logic [SIDE-1:0]      inf_q;
  logic [CW-1:0]        i_q, j_q, c0_q, c1_q, r0_q;
  logic signed [DW-1:0] pur0_q, delta_q;
  logic                 delta_inf_q;
  logic [TW-1:0]        total_q;
  logic                 out_valid_q;
  logic [TOTAL_BITS-1:0] out_total_q;

  logic [WEIGHT_BITS-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]          ram_raddr, ram_waddr;
  logic [31:0]            raddr_full, waddr_full, wdata_full;
  logic [CW-1:0]          owner_addr, owner_rd, pu_addr, pred_c0, rd_row;
  logic signed [DW-1:0]   w_s, cur, s_new;
  logic                   take, better;
  logic [TW+TOTAL_BITS-1:0] total_ext;

  // weight store
  assign waddr_full = 32'(wr_row_i) * MAX_SIZE + 32'(wr_col_i);
  assign ram_waddr  = waddr_full[AW-1:0];
  assign wdata_full = {16'b0, wr_weight_i};
  assign ram_wdata  = wdata_full[WEIGHT_BITS-1:0];

  assign pred_c0 = pred_q[c0_q];

  always_comb begin
    case (cmd_i.op)
      CMD_UPDATE, CMD_SUM_RD: owner_addr = j_q;
      CMD_AUG:                owner_addr = pred_c0;
      default:                owner_addr = c0_q;
    endcase
  end
  assign owner_rd = owner_q[owner_addr];
  assign pu_addr  = (cmd_i.op == CMD_UPDATE) ? owner_rd : r0_q;

  // 1-based row and column to row-major address
  assign rd_row     = (cmd_i.op == CMD_SUM_RD) ? owner_rd : r0_q;
  assign raddr_full = (32'(rd_row) - 32'd1) * MAX_SIZE + (32'(j_q) - 32'd1);
  assign ram_raddr  = raddr_full[AW-1:0];

  mwa_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_wram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // reduced cost of the current column against the tree row
  assign w_s    = DW'($signed({1'b0, ram_rdata}));
  assign cur    = -w_s - pur0_q - pv_q[j_q];
  assign take   = inf_q[j_q] || (cur < slack_q[j_q]);
  assign s_new  = take ? cur : slack_q[j_q];
  assign better = delta_inf_q || (s_new < delta_q);

  assign total_ext = {{TOTAL_BITS{1'b0}}, total_q};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_START: begin
        for (int k = 0; k < SIDE; k++) begin
          owner_q[k] <= '0;
          pu_q[k]    <= '0;
          pv_q[k]    <= '0;
        end
        i_q <= CW'(1);
      end
      CMD_ROW_INIT: begin
        owner_q[0] <= i_q;
        c0_q       <= '0;
        used_q     <= '0;
        inf_q      <= '1;
      end
      CMD_SETUP: begin
        r0_q         <= owner_rd;
        used_q[c0_q] <= 1'b1;
        j_q          <= CW'(1);
        delta_inf_q  <= 1'b1;
      end
      CMD_SCAN_RD: begin
        pur0_q <= pu_q[pu_addr];
      end
      CMD_SCAN_EV: begin
        if (!used_q[j_q]) begin
          if (take) begin
            slack_q[j_q] <= cur;
            inf_q[j_q]   <= 1'b0;
            pred_q[j_q]  <= c0_q;
          end
          if (better) begin
            delta_q     <= s_new;
            delta_inf_q <= 1'b0;
            c1_q        <= j_q;
          end
        end
        j_q <= (j_q == n_i) ? '0 : j_q + CW'(1);
      end
      CMD_UPDATE: begin
        if (used_q[j_q]) begin
          pu_q[pu_addr] <= pu_q[pu_addr] + delta_q;
          pv_q[j_q]     <= pv_q[j_q] - delta_q;
        end else begin
          slack_q[j_q] <= slack_q[j_q] - delta_q;
        end
        j_q <= j_q + CW'(1);
        if (j_q == n_i) c0_q <= c1_q;
      end
      CMD_AUG: begin
        owner_q[c0_q] <= owner_rd;
        c0_q          <= pred_c0;
        if (pred_c0 == '0) begin
          i_q     <= i_q + CW'(1);
          j_q     <= CW'(1);
          total_q <= '0;
        end
      end
      CMD_SUM_ADD: begin
        total_q <= total_q + TW'(ram_rdata);
        j_q     <= j_q + CW'(1);
      end
      CMD_EMIT: begin
        out_total_q <= (total_ext > SAT_LIMIT) ? {TOTAL_BITS{1'b1}}
                                               : total_ext[TOTAL_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == CMD_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_total_o = out_total_q;

  assign status_o.j_last     = (j_q == n_i);
  assign status_o.owner_zero = (owner_rd == '0);
  assign status_o.aug_last   = (pred_c0 == '0);
  assign status_o.row_last   = (i_q == n_i);
  assign status_o.out_busy   = out_valid_q;

  `MWA_ASSERT(a_root_used, clk_i, rst_ni,
              (cmd_i.op == CMD_UPDATE && j_q == '0) |-> used_q[0])
  `MWA_ASSERT(a_aug_nonroot, clk_i, rst_ni, (cmd_i.op == CMD_AUG) |-> (c0_q != '0))
  `MWA_ASSERT_NEXT(a_emit_sets_valid, clk_i, rst_ni,
                   (cmd_i.op == CMD_EMIT && !out_valid_q), out_valid_q)
endmodule

FILE: rtl/max_weight_assignment.sv
// top level of the maximum-weight assignment solver
// depends on mwa_pkg, mwa_if, mwa_ctrl, mwa_dp
//
// channel    dir  handshake        payload
// in_chan_i  in   valid / ready    row_index, col_index, weight, last_entry
// out_chan_o out  valid / ready    total_weight
// apb        in   psel / penable   paddr, pwdata, prdata (size_in_use at 0)
//
// an accepted entry in range is written to the weight store; the entry marked last then starts a solve
// the solve runs row by row; each search phase sets up the tree row, reads and
// evaluates the weight of each column (the weight read is registered), updates
// every column, then checks the owner; after the last row the weights are summed
// no entries are taken during the solve; a finished result waits in the
// output register while the next matrix loads
// reset clears the state machine and the output valid and sets the size register to 16
module max_weight_assignment #(
  parameter int MAX_SIZE    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mwa_in_if.sink                       in_chan_i,
  mwa_out_if.source                    out_chan_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mwa_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mwa_pkg::*;

  localparam int CW = $clog2(MAX_SIZE + 1);

  logic [SIZE_BITS-1:0] size_q;
  logic [CW-1:0]        n_eff;
  logic                 in_ready, in_accept, in_range;
  dp_cmd_t              cmd;
  dp_status_t           status;

  // register file: one register at word zero
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_SIZE_ADDR[APB_AW-1])) begin
      size_q <= pwdata[SIZE_BITS-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_SIZE_ADDR[APB_AW-1]) ? 32'(size_q) : 32'd0;

  // size in use clamped to 1..MAX_SIZE
  always_comb begin
    if (size_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(size_q) > 32'(MAX_SIZE)) begin
      n_eff = CW'(MAX_SIZE);
    end else begin
      n_eff = CW'(size_q);
    end
  end

  // entries outside the store are dropped, the last flag still counts
  assign in_chan_i.ready = in_ready;
  assign in_accept = in_chan_i.valid && in_ready;
  assign in_range  = (32'(in_chan_i.row_index) < 32'(MAX_SIZE))
                  && (32'(in_chan_i.col_index) < 32'(MAX_SIZE));

  mwa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_chan_i.valid),
    .in_last_i (in_chan_i.last_entry),
    .in_ready_o(in_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  mwa_dp #(.MAX_SIZE(MAX_SIZE), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .wr_en_i    (in_accept && in_range),
    .wr_row_i   (in_chan_i.row_index),
    .wr_col_i   (in_chan_i.col_index),
    .wr_weight_i(in_chan_i.weight),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_chan_o.valid),
    .out_ready_i(out_chan_o.ready),
    .out_total_o(out_chan_o.total_weight)
  );
endmodule

FILE: tb/max_weight_assignment_tb.sv
// self-checking testbench of the maximum-weight assignment solver
// depends on mwa_pkg, mwa_if and max_weight_assignment from the rtl folder
module max_weight_assignment_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mwa_pkg::*;

  localparam int SIDE_MAX   = 16;
  localparam int ENTRY_GOAL = 1600;
  localparam int QUIET_FROM = 1400;   // no idling once more than this many entries are queued
  localparam int STALL_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [WIN_BITS-1:0] weight;
    logic                last;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  mwa_in_if  in_ch ();
  mwa_out_if out_ch ();

  max_weight_assignment uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_ch),
    .out_chan_o (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #10 clk_i = ~clk_i;

  // predictor state: its own copy of the matrix store and the size register
  logic [WIN_BITS-1:0]  matrix_copy [SIDE_MAX][SIDE_MAX];
  logic [SIZE_BITS-1:0] size_copy = SIZE_RESET;
  bit                   ever_written [SIDE_MAX][SIDE_MAX];  // generator side only

  entry_t              entry_q[$];     // transactions waiting for the driver
  logic [TOTAL_BITS-1:0] total_q[$];   // predicted totals not yet seen
  int  error_count = 0;
  int  entries_queued = 0;
  int  entries_taken = 0;
  int  totals_seen = 0;
  int  size_min_used = SIDE_MAX, size_max_used = 0;
  bit  quiet = 1'b0;                   // idling switched off
  bit  stimulus_done = 1'b0;

  task automatic report(input string what, input int exp_v, input int got_v);
    error_count++;
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
  endtask

  // hungarian method on negated weights with row and column potentials
  function automatic logic [TOTAL_BITS-1:0] best_total(input int n);
    longint u [SIDE_MAX+1];
    longint v [SIDE_MAX+1];
    longint slack [SIDE_MAX+1];
    int     holder [SIDE_MAX+1];
    int     via [SIDE_MAX+1];
    bit     seen [SIDE_MAX+1];
    longint sum;
    longint delta, cur;
    int     c0, c1, r0;
    for (int j = 0; j <= SIDE_MAX; j++) begin
      u[j] = 0; v[j] = 0; holder[j] = 0; via[j] = 0;
    end
    for (int i = 1; i <= n; i++) begin
      holder[0] = i;
      c0 = 0;
      for (int j = 0; j <= n; j++) begin
        slack[j] = 64'sd1 <<< 60;
        seen[j] = 1'b0;
      end
      do begin
        seen[c0] = 1'b1;
        r0 = holder[c0];
        delta = 64'sd1 <<< 60;
        c1 = 0;
        for (int j = 1; j <= n; j++) begin
          if (!seen[j]) begin
            cur = -longint'(matrix_copy[r0-1][j-1]) - u[r0] - v[j];
            if (cur < slack[j]) begin
              slack[j] = cur;
              via[j] = c0;
            end
            if (slack[j] < delta) begin
              delta = slack[j];
              c1 = j;
            end
          end
        end
        for (int j = 0; j <= n; j++) begin
          if (seen[j]) begin
            u[holder[j]] += delta;
            v[j] -= delta;
          end else begin
            slack[j] -= delta;
          end
        end
        c0 = c1;
      end while (holder[c0] != 0);
      do begin
        c1 = via[c0];
        holder[c0] = holder[c1];
        c0 = c1;
      end while (c0 != 0);
    end
    sum = 0;
    for (int j = 1; j <= n; j++) sum += matrix_copy[holder[j]-1][j-1];
    if (sum > 64'd1048575) sum = 64'd1048575;
    return sum[TOTAL_BITS-1:0];
  endfunction

  // every input starts known
  initial begin
    in_ch.valid = 1'b0;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.weight = '0;
    in_ch.last_entry = 1'b0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
  end

  // driver: presents queued entries, idles in random bursts
  int send_gap = 0;
  always @(posedge clk_i) begin
    entry_t nxt;
    int n;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        // accepted entry updates the predictor store, last entry predicts a total
        matrix_copy[in_ch.row_index][in_ch.col_index] = in_ch.weight;
        entries_taken++;
        if (in_ch.last_entry) begin
          n = int'(size_copy);
          if (n < 1) n = 1;
          if (n > SIDE_MAX) n = SIDE_MAX;
          total_q = {total_q, best_total(n)};
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (entry_q.size() > 0) begin
          nxt = entry_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.row_index  <= nxt.row;
          in_ch.col_index  <= nxt.col;
          in_ch.weight     <= nxt.weight;
          in_ch.last_entry <= nxt.last;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compares totals in order
  int recv_gap = 0;
  always @(posedge clk_i) begin
    logic [TOTAL_BITS-1:0] want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        totals_seen++;
        if (total_q.size() == 0) begin
          report("unexpected total_weight", -1, int'(out_ch.total_weight));
        end else begin
          want = total_q.pop_front();
          if (out_ch.total_weight !== want)
            report("total_weight", int'(want), int'(out_ch.total_weight));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 9);
      end
    end
  end

  // watchdog: cycles in a row with no transaction on either channel
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || stimulus_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d totals pending", total_q.size());
      $display("max_weight_assignment_tb: errors");
      $finish;
    end
  end

  // apb write: setup cycle then access cycle, register written at the access edge
  task automatic write_size(input int value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_SIZE_ADDR; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    size_copy = value[SIZE_BITS-1:0];
  endtask

  // block is idle once every total is back and the solver has settled
  task automatic wait_idle();
    while (entry_q.size() > 0 || in_ch.valid || total_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic push_entry(input int r, input int c, input int w, input bit last);
    entry_t e;
    e.row = ROW_BITS'(r); e.col = COL_BITS'(c); e.weight = WIN_BITS'(w); e.last = last;
    entry_q = {entry_q, e};
    ever_written[r][c] = 1'b1;
    entries_queued++;
  endtask

  function automatic int pick_weight();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 3);         // many ties
      3: return $urandom_range(65500, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one matrix: covers every square entry not yet written (or all when full), then random
  // content, noise anywhere in the store, and the last entry mostly in the square, sometimes below it
  task automatic send_matrix(input int n, input bit full);
    int cells[$];
    int k, tmp;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (full || !ever_written[r][c] || $urandom_range(0, 2) == 0) cells = {cells, r*16 + c};
    for (int i = cells.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = cells[i]; cells[i] = cells[k]; cells[k] = tmp;
    end
    foreach (cells[i]) begin
      if ($urandom_range(0, 9) == 0)
        push_entry($urandom_range(0, 15), $urandom_range(0, 15), pick_weight(), 1'b0);
      push_entry(cells[i] / 16, cells[i] % 16, pick_weight(), 1'b0);
    end
    if ($urandom_range(0, 4) == 0 && n < SIDE_MAX)
      push_entry($urandom_range(n, 15), $urandom_range(0, 15), pick_weight(), 1'b1);
    else
      push_entry($urandom_range(0, n-1), $urandom_range(0, n-1), pick_weight(), 1'b1);
  endtask

  function automatic int clip_size(input int s);
    return (s < 1) ? 1 : (s > SIDE_MAX ? SIDE_MAX : s);
  endfunction

  initial begin
    int s, big_left;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one by one matrices at both weight extremes
    write_size(1);
    push_entry(0, 0, 0, 1'b1);
    push_entry(0, 0, 16'hFFFF, 1'b1);
    // two by two where the diagonal loses to the anti-diagonal
    wait_idle();
    write_size(2);
    push_entry(0, 0, 16'hFFFF, 1'b0);
    push_entry(0, 1, 16'hFFFE, 1'b0);
    push_entry(1, 0, 16'hFFFF, 1'b0);
    push_entry(1, 1, 0, 1'b1);
    // all ties, then last entry outside the square only re-solves
    push_entry(0, 0, 7, 1'b0);
    push_entry(0, 1, 7, 1'b0);
    push_entry(1, 0, 7, 1'b0);
    push_entry(1, 1, 7, 1'b1);
    push_entry(15, 15, 16'hAAAA, 1'b1);
    push_entry(9, 6, 16'h5555, 1'b1);
    // size zero acts as one
    wait_idle();
    write_size(0);
    push_entry(0, 0, 16'h1234, 1'b1);
    // sender holds off until every total is back
    wait_idle();
    // size beyond the range acts as the full size, all at the top weight
    write_size(31);
    for (int r = 0; r < SIDE_MAX; r++)
      for (int c = 0; c < SIDE_MAX; c++)
        push_entry(r, c, 16'hFFFF, (r == SIDE_MAX-1) && (c == SIDE_MAX-1));
    wait_idle();
    write_size(16);
    send_matrix(16, 1'b0);

    // random phases, mostly small sizes
    big_left = 2;
    while (entries_queued < ENTRY_GOAL) begin
      wait_idle();
      if (entries_queued > QUIET_FROM) quiet = 1'b1;
      if (big_left > 0 && $urandom_range(0, 19) == 0) begin
        s = $urandom_range(0, 1) ? 16 : $urandom_range(17, 31);
        big_left--;
      end else begin
        s = $urandom_range(0, 7);
      end
      write_size(s);
      size_min_used = (clip_size(s) < size_min_used) ? clip_size(s) : size_min_used;
      size_max_used = (clip_size(s) > size_max_used) ? clip_size(s) : size_max_used;
      repeat ($urandom_range(1, 3)) send_matrix(clip_size(s), $urandom_range(0, 2) != 0);
    end

    wait_idle();
    stimulus_done = 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (total_q.size() > 0) report("totals never produced", 0, total_q.size());
    $display("run covered %0d entries and %0d totals", entries_taken, totals_seen);
    $display("random sizes %0d to %0d, plus size zero and oversize", size_min_used,
             size_max_used);
    if (error_count == 0) begin
      $display("max_weight_assignment_tb: clean");
    end else begin
      $display("max_weight_assignment_tb: errors");
    end
    $finish;
  end

endmodule
